/* src/mavlink_v1_frame_builder_assert.svh */
// ----------------------------------------------------------------------------
// mavlink v1 frame builder assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset masked
// ----------------------------------------------------------------------------
`ifndef MAVLINK_V1_FRAME_BUILDER_ASSERT_SVH
`define MAVLINK_V1_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define MVFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvfb assertion failed");

// next-cycle implication
`define MVFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvfb assertion failed");

`endif

/* src/mvfb_pkg.sv */
// ----------------------------------------------------------------------------
// mvfb_pkg
// types, constants and the x.25 crc step shared by the frame builder modules
// ----------------------------------------------------------------------------
package mvfb_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CRC_W      = 16;
   localparam int unsigned CSR_IDX_W  = 8;

   localparam logic [BYTE_W-1:0] START_MARK    = 8'hFE;
   localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
   localparam logic [BYTE_W-1:0] SYS_ID_RESET  = 8'd81;
   localparam logic [BYTE_W-1:0] COMP_ID_RESET = 8'd50;
   localparam logic [BYTE_W-1:0] COUNT_MAX     = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_SYSTEM_ID    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPONENT_ID = 8'd1;

   typedef enum logic [3:0] {
      PH_START,
      PH_LEN,
      PH_SEQ,
      PH_SYS,
      PH_COMP,
      PH_MSG,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   typedef struct packed {
      logic              init;
      logic              feed;
      logic [BYTE_W-1:0] data;
   } crc_ctrl_type;

   // one byte of the reflected x.25 crc
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
             ^ {12'h000, t[7:4]};
   endfunction

endpackage

/* src/mvfb_crc.sv */
// ----------------------------------------------------------------------------
// mvfb_crc
// crc accumulator: restarts at 0xffff or takes one byte per cycle
// ----------------------------------------------------------------------------
module mvfb_crc (
   input  logic                         clock,
   input  logic                         reset,
   input  mvfb_pkg::crc_ctrl_type       ctrl,
   output logic [mvfb_pkg::CRC_W-1:0]   crc_value,
   output logic [mvfb_pkg::CRC_W-1:0]   crc_fed
);
   import mvfb_pkg::*;

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;

   assign crc_fed   = crc_feed(crc_ff, ctrl.data);
   assign crc_value = crc_ff;

   always_comb begin
      priority if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.feed) begin
         crc_in = crc_fed;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

/* src/mavlink_v1_frame_builder.sv */
// ----------------------------------------------------------------------------
// mavlink_v1_frame_builder
// wraps payload bytes into mavlink v1 frames with header, sequence and crc
// ----------------------------------------------------------------------------
// req channel: one payload byte per transaction, with first/last marks and,
// on the first byte, length, message id and crc-extra seed.
// rsp channel: one wire byte per transaction; frame_end marks the crc high
// byte and length_error on it flags a byte count that missed the length.
// csr channel: index 0 system id, index 1 component id; always ready, other
// indexes are dropped. write it only while no frame bytes are in flight.
// the first rsp byte passes the held item register, then the output register.
// throughput: one output byte per cycle unless rsp_stall holds it, from a
// one-byte-per-cycle emitter; a first byte emits start mark, length, sequence,
// ids and message id before itself, a last byte adds crc low and high after.
// req_stall is high while the held item still has bytes to emit; the next item
// is taken in the cycle its final byte goes out. reset: sequence 0, crc 0xffff,
// counters clear, ids 81 and 50, both channels empty. rsp_stall freezes the
// output byte and the emitter; the held input item then keeps req_stall high.
// ----------------------------------------------------------------------------
`include "mavlink_v1_frame_builder_assert.svh"

module mavlink_v1_frame_builder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mvfb_pkg::BYTE_W-1:0]        req_payload_byte,
   input  logic                               req_first_byte,
   input  logic                               req_last_byte,
   input  logic [mvfb_pkg::BYTE_W-1:0]        req_payload_len,
   input  logic [mvfb_pkg::BYTE_W-1:0]        req_msg_id,
   input  logic [mvfb_pkg::BYTE_W-1:0]        req_crc_extra,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mvfb_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_frame_end,
   output logic                               rsp_length_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mvfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvfb_pkg::BYTE_W-1:0]        csr_wdata
);
   import mvfb_pkg::*;

   // config
   logic [BYTE_W-1:0] sys_id_ff, sys_id_in;
   logic [BYTE_W-1:0] comp_id_ff, comp_id_in;

   // held input item
   logic              item_valid_ff, item_valid_in;
   logic [BYTE_W-1:0] pb_ff, pb_in;
   logic              last_ff, last_in;
   logic [BYTE_W-1:0] plen_ff, plen_in;
   logic [BYTE_W-1:0] mid_ff, mid_in;
   logic [BYTE_W-1:0] seed_ff, seed_in;
   phase_type         phase_ff, phase_in;

   // frame state
   logic [BYTE_W-1:0] seq_ff, seq_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] exp_len_ff, exp_len_in;
   logic [BYTE_W-1:0] seed_latch_ff, seed_latch_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              frame_end_ff, frame_end_in;
   logic              len_err_ff, len_err_in;

   logic              advance;
   logic              item_done;
   logic              req_take;
   logic [BYTE_W-1:0] data_byte;
   crc_ctrl_type      crc_ctrl;
   logic [CRC_W-1:0]  crc_value;
   logic [CRC_W-1:0]  crc_fed;

   mvfb_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .crc_value (crc_value),
      .crc_fed   (crc_fed)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      sys_id_in  = sys_id_ff;
      comp_id_in = comp_id_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SYSTEM_ID) begin
            sys_id_in = csr_wdata;
         end else if (csr_index == CSR_COMPONENT_ID) begin
            comp_id_in = csr_wdata;
         end
      end
   end

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign item_done = (phase_ff == PH_CRC_HI) || ((phase_ff == PH_PAYLOAD) && !last_ff);
   assign req_stall = item_valid_ff && !(advance && item_done);
   assign req_take  = req_valid && !req_stall;

   // header and payload bytes, then the crc-extra seed; all but the start mark enter the crc
   always_comb begin
      unique case (phase_ff)
         PH_START:   data_byte = START_MARK;
         PH_LEN:     data_byte = plen_ff;
         PH_SEQ:     data_byte = seq_ff;
         PH_SYS:     data_byte = sys_id_ff;
         PH_COMP:    data_byte = comp_id_ff;
         PH_MSG:     data_byte = mid_ff;
         PH_PAYLOAD: data_byte = pb_ff;
         PH_CRC_LO:  data_byte = seed_latch_ff;
         PH_CRC_HI:  data_byte = seed_latch_ff;
         default:    data_byte = pb_ff;
      endcase
   end

   always_comb begin
      crc_ctrl.init = advance && (phase_ff == PH_START);
      crc_ctrl.feed = advance && (phase_ff != PH_START) && (phase_ff != PH_CRC_HI);
      crc_ctrl.data = data_byte;
   end

   always_comb begin
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      count_in      = count_ff;
      exp_len_in    = exp_len_ff;
      seed_latch_in = seed_latch_ff;
      out_byte_in   = data_byte;
      frame_end_in  = 1'b0;
      len_err_in    = 1'b0;

      unique case (phase_ff)
         PH_START: begin
            phase_in = PH_LEN;
            if (advance) begin
               exp_len_in    = plen_ff;
               seed_latch_in = seed_ff;
               count_in      = '0;
            end
         end
         PH_LEN:  phase_in = PH_SEQ;
         PH_SEQ:  phase_in = PH_SYS;
         PH_SYS:  phase_in = PH_COMP;
         PH_COMP: phase_in = PH_MSG;
         PH_MSG: begin
            phase_in = PH_PAYLOAD;
            if (advance) begin
               seq_in = seq_ff + 8'd1;
            end
         end
         PH_PAYLOAD: begin
            phase_in = PH_CRC_LO;
            if (advance && (count_ff != COUNT_MAX)) begin
               count_in = count_ff + 8'd1;
            end
         end
         PH_CRC_LO: begin
            phase_in    = PH_CRC_HI;
            out_byte_in = crc_fed[7:0];
         end
         PH_CRC_HI: begin
            phase_in     = PH_CRC_HI;
            out_byte_in  = crc_value[15:8];
            frame_end_in = 1'b1;
            len_err_in   = (count_ff != exp_len_ff);
         end
         default: phase_in = PH_PAYLOAD;
      endcase

      if (!advance) begin
         phase_in = phase_ff;
      end
      if (req_take) begin
         phase_in = req_first_byte ? PH_START : PH_PAYLOAD;
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      pb_in         = pb_ff;
      last_in       = last_ff;
      plen_in       = plen_ff;
      mid_in        = mid_ff;
      seed_in       = seed_ff;
      if (advance && item_done) begin
         item_valid_in = 1'b0;
      end
      if (req_take) begin
         item_valid_in = 1'b1;
         pb_in         = req_payload_byte;
         last_in       = req_last_byte;
         plen_in       = req_payload_len;
         mid_in        = req_msg_id;
         seed_in       = req_crc_extra;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_id_ff     <= SYS_ID_RESET;
         comp_id_ff    <= COMP_ID_RESET;
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_PAYLOAD;
         seq_ff        <= '0;
         count_ff      <= '0;
         exp_len_ff    <= '0;
         seed_latch_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sys_id_ff     <= sys_id_in;
         comp_id_ff    <= comp_id_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         seq_ff        <= seq_in;
         count_ff      <= count_in;
         exp_len_ff    <= exp_len_in;
         seed_latch_ff <= seed_latch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pb_ff   <= pb_in;
      last_ff <= last_in;
      plen_ff <= plen_in;
      mid_ff  <= mid_in;
      seed_ff <= seed_in;
      if (advance) begin
         out_byte_ff  <= out_byte_in;
         frame_end_ff <= frame_end_in;
         len_err_ff   <= len_err_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_frame_end    = frame_end_ff;
   assign rsp_length_error = len_err_ff;

   // checks
   `MVFB_ASSERT_NEXT(a_take_loads_item, clock, reset, req_take, item_valid_ff)
   `MVFB_ASSERT_NOW(a_idle_never_stalls, clock, reset, !item_valid_ff, !req_stall)
   `MVFB_ASSERT_NEXT(a_start_mark_out, clock, reset, advance && (phase_ff == PH_START),
                     rsp_valid && (rsp_out_byte == START_MARK) && !rsp_frame_end)
   `MVFB_ASSERT_NEXT(a_crc_hi_ends_frame, clock, reset, advance && (phase_ff == PH_CRC_HI),
                     rsp_valid && rsp_frame_end)
   `MVFB_ASSERT_NOW(a_err_only_at_end, clock, reset, rsp_valid && rsp_length_error, rsp_frame_end)

endmodule
